// ===== hw/rtl/bloom_filter_engine_core_macros.svh =====
// Assertion macros used by the checker file of the bloom filter engine.
// Depends on nothing; included by the checker module.
`ifndef BLOOM_FILTER_ENGINE_CORE_MACROS_SVH
`define BLOOM_FILTER_ENGINE_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define BFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bfe check failed");

// The consequent must hold in the same cycle as the antecedent.
`define BFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bfe check failed");

`endif

// ===== hw/rtl/bfe_pkg.sv =====
// Types and constants of the bloom filter engine.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bfe_pkg;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] REG_FILTER_SIZE = 2'd0;
	localparam logic [1:0] REG_HASH_COUNT  = 2'd1;
	localparam logic [1:0] REG_SEED_ONE    = 2'd2;
	localparam logic [1:0] REG_SEED_TWO    = 2'd3;

	localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2  = 32'h1b873593;
	localparam logic [31:0] MM_ADD = 32'he6546b64;
	localparam logic [31:0] MM_F1  = 32'h85ebca6b;
	localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

	localparam logic [4:0] DIV_LAST = 5'd31;

	typedef enum logic [2:0] {
		HO_IDLE,
		HO_BYTE,
		HO_TAIL,
		HO_K1,
		HO_K2,
		HO_ABS,
		HO_FX,
		HO_FM
	} hash_op_t;

	typedef struct packed {
		hash_op_t    op;
		logic        first;
		logic [7:0]  data;
	} hash_cmd_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_ABS,
		ST_TAIL,
		ST_FX,
		ST_FM,
		ST_FD,
		ST_INIT,
		ST_POS,
		ST_DIV,
		ST_MEM,
		ST_DONE
	} state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bfe_hash.sv =====
// Two MurmurHash3 x86_32 digests computed side by side, one operation a cycle.
// Depends on bfe_pkg; driven by the sequencer in the top level.
`default_nettype none
module bfe_hash
	import bfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire hash_cmd_t   cmd,
	input  wire logic [31:0] seed_one,
	input  wire logic [31:0] seed_two,
	output logic             full,
	output logic [31:0]      hash_one,
	output logic [31:0]      hash_two
);

	logic [31:0] h1_q, h2_q, k_q, len_q;
	logic [23:0] buf_q;
	logic [31:0] h1_cur, h2_cur, len_cur;
	logic [23:0] buf_cur, buf_ins;
	logic [31:0] x1, x2;

	always_comb begin
		h1_cur  = cmd.first ? seed_one : h1_q;
		h2_cur  = cmd.first ? seed_two : h2_q;
		buf_cur = cmd.first ? 24'd0 : buf_q;
		len_cur = cmd.first ? 32'd0 : len_q;
		full    = (len_cur[1:0] == 2'd3);
		unique case (len_cur[1:0])
			2'd0:    buf_ins = {16'd0, cmd.data};
			2'd1:    buf_ins = {8'd0, cmd.data, 8'd0};
			default: buf_ins = {cmd.data, 16'd0};
		endcase
		x1 = h1_q ^ k_q ^ len_q;
		x2 = h2_q ^ k_q ^ len_q;
		x1 = x1 ^ (x1 >> 16);
		x2 = x2 ^ (x2 >> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q  <= '0;
			h2_q  <= '0;
			k_q   <= '0;
			len_q <= '0;
			buf_q <= '0;
		end else begin
			unique case (cmd.op)
				HO_BYTE: begin
					h1_q  <= h1_cur;
					h2_q  <= h2_cur;
					len_q <= len_cur + 32'd1;
					if (full) begin
						k_q   <= {cmd.data, buf_cur};
						buf_q <= '0;
					end else begin
						buf_q <= buf_cur | buf_ins;
					end
				end
				HO_TAIL: k_q <= {8'd0, buf_q};
				HO_K1:   k_q <= k_q * MM_C1;
				HO_K2:   k_q <= rotl(k_q, 15) * MM_C2;
				HO_ABS: begin
					h1_q <= (rotl(h1_q ^ k_q, 13) << 2) + rotl(h1_q ^ k_q, 13) + MM_ADD;
					h2_q <= (rotl(h2_q ^ k_q, 13) << 2) + rotl(h2_q ^ k_q, 13) + MM_ADD;
				end
				HO_FX: begin
					h1_q <= x1 * MM_F1;
					h2_q <= x2 * MM_F1;
				end
				HO_FM: begin
					h1_q <= (h1_q ^ (h1_q >> 13)) * MM_F2;
					h2_q <= (h2_q ^ (h2_q >> 13)) * MM_F2;
				end
				default: begin
				end
			endcase
		end
	end

	assign hash_one = h1_q ^ (h1_q >> 16);
	assign hash_two = h2_q ^ (h2_q >> 16);

endmodule
`default_nettype wire

// ===== hw/rtl/bfe_mem.sv =====
// Single-port bit store of the filter with a registered read.
// Depends on bfe_pkg only through the common house style.
`default_nettype none
module bfe_mem
	import bfe_pkg::*;
#(
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     wdata,
	output logic                          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bloom_filter_engine_core.sv =====
// Top level of the bloom filter engine: configuration, sequencer, modulo unit.
// Depends on bfe_pkg, bfe_hash and bfe_mem.
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tdata key byte, tlast last byte, tuser mode
// m_*       out        m_tvalid/m_tready  tdata maybe_present
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// A key byte is taken in the idle state; one that completes a 32-bit block then runs
// K1, K2 and ABS. The last byte adds the finishing states TAIL, K1, K2, FX, FM, FD and
// INIT, then POS, DIV and MEM for each bit position, a closing POS and DONE for a query:
// the remainder is found by a restoring divider at one quotient bit a cycle.
// After reset and after each clear request all FILTER_BITS bits of the store are swept to zero.
// A finished answer waits in an output register; the next key streams meanwhile.
`default_nettype none
module bloom_filter_engine_core
	import bfe_pkg::*;
#(
	parameter int FILTER_BITS = 65536,
	parameter int MAX_HASHES  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
	input  wire logic        s_tlast,
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [0] maybe_present
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(FILTER_BITS);
	localparam int SW = $clog2(FILTER_BITS + 1);
	localparam int CW = $clog2(MAX_HASHES + 1);
	localparam logic [31:0] FB32 = 32'(FILTER_BITS);
	localparam logic [31:0] MH32 = 32'(MAX_HASHES);
	localparam logic [AW-1:0] SWEEP_END = AW'(FILTER_BITS - 1);

	logic [16:0] filter_size_q;
	logic [5:0]  hash_count_q;
	logic [31:0] seed_one_q, seed_two_q;

	state_t state_q, state_d;
	hash_cmd_t cmd;
	logic hfull;
	logic [31:0] d1, d2;

	logic key_open_q, last_q, fin_q, all_q, rd_pend_q;
	logic [1:0] mode_q;
	logic [AW-1:0] sweep_q;
	logic [31:0] acc_q, div_q;
	logic [SW-1:0] size_q, r_q;
	logic [CW-1:0] cnt_q, i_q;
	logic [4:0] bit_q;
	logic out_valid_q, out_bit_q;

	logic accept, all_c;
	logic [31:0] size32, cnt32, mag;
	logic [SW:0] trial;
	logic mem_we, mem_re, mem_wdata, mem_rdata;
	logic [AW-1:0] mem_addr;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_size_q <= 17'd65536;
			hash_count_q  <= 6'd7;
			seed_one_q    <= 32'd0;
			seed_two_q    <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_SIZE: filter_size_q <= cfg_data[16:0];
				REG_HASH_COUNT:  hash_count_q  <= cfg_data[5:0];
				REG_SEED_ONE:    seed_one_q    <= cfg_data;
				REG_SEED_TWO:    seed_two_q    <= cfg_data;
			endcase
		end
	end

	bfe_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.seed_one (seed_one_q),
		.seed_two (seed_two_q),
		.full     (hfull),
		.hash_one (d1),
		.hash_two (d2)
	);

	bfe_mem #(.DEPTH(FILTER_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		size32 = {15'd0, filter_size_q};
		if (size32 == 32'd0) begin
			size32 = 32'd1;
		end else if (size32 > FB32) begin
			size32 = FB32;
		end
		cnt32 = {26'd0, hash_count_q};
		if (cnt32 > MH32) begin
			cnt32 = MH32;
		end
		mag   = acc_q[31] ? (~acc_q + 32'd1) : acc_q;
		trial = {r_q, div_q[31]};
		all_c = all_q && (!rd_pend_q || mem_rdata);
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = HO_IDLE;
		cmd.first = !key_open_q;
		cmd.data  = s_tdata;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = 1'b0;
		mem_addr  = r_q[AW-1:0];
		unique case (state_q)
			ST_SWEEP: begin
				mem_we   = 1'b1;
				mem_addr = sweep_q;
				if (sweep_q == SWEEP_END) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					priority if (s_tuser == MODE_CLEAR) begin
						state_d = ST_SWEEP;
					end else if (s_tuser == MODE_NONE) begin
						state_d = ST_IDLE;
					end else begin
						cmd.op = HO_BYTE;
						if (hfull) begin
							state_d = ST_K1;
						end else if (s_tlast) begin
							state_d = ST_TAIL;
						end
					end
				end
			end
			ST_TAIL: begin
				cmd.op  = HO_TAIL;
				state_d = ST_K1;
			end
			ST_K1: begin
				cmd.op  = HO_K1;
				state_d = ST_K2;
			end
			ST_K2: begin
				cmd.op  = HO_K2;
				state_d = fin_q ? ST_FX : ST_ABS;
			end
			ST_ABS: begin
				cmd.op  = HO_ABS;
				state_d = last_q ? ST_TAIL : ST_IDLE;
			end
			ST_FX: begin
				cmd.op  = HO_FX;
				state_d = ST_FM;
			end
			ST_FM: begin
				cmd.op  = HO_FM;
				state_d = ST_FD;
			end
			ST_FD: state_d = ST_INIT;
			ST_INIT: state_d = ST_POS;
			ST_POS: begin
				if (i_q == cnt_q) begin
					state_d = (mode_q == MODE_QUERY) ? ST_DONE : ST_IDLE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_q == DIV_LAST) begin
					state_d = ST_MEM;
				end
			end
			ST_MEM: begin
				if (mode_q == MODE_ADD) begin
					mem_we    = 1'b1;
					mem_wdata = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
				state_d = ST_POS;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			key_open_q  <= 1'b0;
			last_q      <= 1'b0;
			fin_q       <= 1'b0;
			mode_q      <= MODE_ADD;
			rd_pend_q   <= 1'b0;
			all_q       <= 1'b1;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: sweep_q <= sweep_q + AW'(1);
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == MODE_CLEAR) begin
							sweep_q    <= '0;
							key_open_q <= 1'b0;
						end else if (s_tuser != MODE_NONE) begin
							key_open_q <= 1'b1;
							last_q     <= s_tlast;
							mode_q     <= s_tuser;
							fin_q      <= 1'b0;
						end
					end
				end
				ST_TAIL: fin_q <= 1'b1;
				ST_INIT: begin
					all_q     <= 1'b1;
					rd_pend_q <= 1'b0;
				end
				ST_POS: begin
					all_q     <= all_c;
					rd_pend_q <= 1'b0;
					if (i_q == cnt_q) begin
						key_open_q <= 1'b0;
					end
				end
				ST_MEM: rd_pend_q <= (mode_q != MODE_ADD);
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_bit_q   <= all_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_INIT: begin
				acc_q  <= d1;
				i_q    <= '0;
				size_q <= SW'(size32);
				cnt_q  <= CW'(cnt32);
			end
			ST_POS: begin
				div_q <= mag;
				r_q   <= '0;
				bit_q <= '0;
			end
			ST_DIV: begin
				div_q <= {div_q[30:0], 1'b0};
				bit_q <= bit_q + 5'd1;
				if (trial >= {1'b0, size_q}) begin
					r_q <= SW'(trial - {1'b0, size_q});
				end else begin
					r_q <= trial[SW-1:0];
				end
			end
			ST_MEM: begin
				acc_q <= acc_q + d2;
				i_q   <= i_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bfe_chk.sv =====
// Port-level checks of the bloom filter engine, bound to the top level.
// Depends on bfe_pkg and bloom_filter_engine_core_macros.svh.
`default_nettype none
`include "bloom_filter_engine_core_macros.svh"
module bfe_chk
	import bfe_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tlast,
	input wire logic [1:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready
);

	`BFE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`BFE_ASSERT_NEXT(a_key_end_stalls, clk, arst_n, s_tvalid && s_tready && s_tlast && (s_tuser == MODE_ADD || s_tuser == MODE_QUERY), !s_tready)
	`BFE_ASSERT_NEXT(a_clear_sweeps, clk, arst_n, s_tvalid && s_tready && s_tuser == MODE_CLEAR, !s_tready)
	`BFE_ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind bloom_filter_engine_core bfe_chk u_bfe_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
`default_nettype wire

// ===== tb/sv/tb_bloom_filter_engine_checker.sv =====
`timescale 1ns / 1ps
// Checker of the bloom filter engine: watches the request, answer and register ports,
// predicts every query answer and compares it. Depends on bfe_pkg.
module tb_bloom_filter_engine_checker
	import bfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tlast,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               err_count,
	output int               pending
);

	localparam int FILTER_BITS = 65536;
	localparam int MAX_HASHES  = 32;

	bit          filter_bits [FILTER_BITS];
	logic [31:0] digest_one, digest_two, word_buf, key_len;
	logic        key_open;
	logic [16:0] size_reg;
	logic [5:0]  count_reg;
	logic [31:0] seed_one_reg, seed_two_reg;
	bit          answers [$];
	int          errors;

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] mix_word(input logic [31:0] k);
		return rot_left(k * MM_C1, 15) * MM_C2;
	endfunction

	function automatic logic [31:0] fold_block(input logic [31:0] h, input logic [31:0] k);
		return rot_left(h ^ mix_word(k), 13) * 32'd5 + MM_ADD;
	endfunction

	function automatic logic [31:0] final_mix(input logic [31:0] h, input logic [31:0] tail,
			input logic [31:0] len);
		logic [31:0] v;
		v = h;
		if (len[1:0] != 2'd0)
			v = v ^ mix_word(tail);
		v = v ^ len;
		v = v ^ (v >> 16);
		v = v * MM_F1;
		v = v ^ (v >> 13);
		v = v * MM_F2;
		v = v ^ (v >> 16);
		return v;
	endfunction

	task automatic take_request(input logic [7:0] kb, input logic last, input logic [1:0] md);
		logic [31:0] d1, d2, sum, mag, pos, fsize, hcount;
		bit all_set;
		all_set = 1;
		if (md == MODE_NONE)
			return;
		if (md == MODE_CLEAR) begin
			filter_bits = '{default: 0};
			word_buf = '0;
			key_len = '0;
			key_open = 0;
			return;
		end
		if (!key_open) begin
			digest_one = seed_one_reg;
			digest_two = seed_two_reg;
			word_buf = '0;
			key_len = '0;
			key_open = 1;
		end
		if (key_len[1:0] == 2'd3) begin
			digest_one = fold_block(digest_one, word_buf | {kb, 24'd0});
			digest_two = fold_block(digest_two, word_buf | {kb, 24'd0});
			word_buf = '0;
		end else begin
			word_buf = word_buf | (32'(kb) << (8 * key_len[1:0]));
		end
		key_len = key_len + 1;
		if (!last)
			return;
		d1 = final_mix(digest_one, word_buf, key_len);
		d2 = final_mix(digest_two, word_buf, key_len);
		fsize = (size_reg == 0) ? 1 : (size_reg > FILTER_BITS) ? FILTER_BITS : size_reg;
		hcount = (count_reg > MAX_HASHES) ? MAX_HASHES : count_reg;
		for (int i = 0; i < hcount; i++) begin
			sum = d1 + 32'(i) * d2;
			mag = sum[31] ? (~sum + 1) : sum;
			pos = mag % fsize;
			if (md == MODE_ADD)
				filter_bits[pos] = 1;
			else if (!filter_bits[pos])
				all_set = 0;
		end
		key_open = 0;
		key_len = '0;
		word_buf = '0;
		if (md == MODE_QUERY)
			answers.push_back(all_set);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			filter_bits = '{default: 0};
			size_reg = 17'd65536;
			count_reg = 6'd7;
			seed_one_reg = 32'd0;
			seed_two_reg = 32'd1;
			key_open = 0;
			key_len = '0;
			word_buf = '0;
			errors = 0;
			answers.delete();
			err_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_SIZE: size_reg = cfg_data[16:0];
					REG_HASH_COUNT:  count_reg = cfg_data[5:0];
					REG_SEED_ONE:    seed_one_reg = cfg_data;
					REG_SEED_TWO:    seed_two_reg = cfg_data;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (answers.size() == 0) begin
					$error("maybe_present with no query waiting: actual %0b", m_tdata[0]);
					errors++;
				end else begin
					want = answers.pop_front();
					if (m_tdata[0] !== want) begin
						$error("maybe_present expected %0b actual %0b", want, m_tdata[0]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				take_request(s_tdata, s_tlast, s_tuser);
			err_count <= errors;
			pending <= answers.size();
		end
	end

endmodule

// ===== tb/sv/tb_bloom_filter_engine_core.sv =====
`timescale 1ns / 1ps
// Top of the bloom filter engine testbench: clock, reset, key and register stimulus.
// Depends on bfe_pkg, bloom_filter_engine_core and tb_bloom_filter_engine_checker.
module tb_bloom_filter_engine_core;
	import bfe_pkg::*;

	localparam int LIMIT = 6000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 0;
	logic [1:0]  s_tuser = MODE_ADD;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [7:0]  m_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_FILTER_SIZE;
	logic [31:0] cfg_data = '0;
	int          err_count, pending;
	int          tx_idle = 0, rx_stall = 0, sent = 0, cycles = 0;
	bit          hold_req = 0, hold_done = 0, clear_seen = 1;

	bloom_filter_engine_core u_top (.*);
	tb_bloom_filter_engine_checker u_chk (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				repeat (5000) @(posedge clk);
				hold_req = 0;
			end
			m_tready <= ($urandom_range(99) >= rx_stall);
		end
	end

	task automatic offer(input logic [7:0] kb, input logic last, input logic [1:0] md);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= kb;
		s_tlast <= last;
		s_tuser <= md;
		if (md == MODE_CLEAR)
			clear_seen = 1;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (clear_seen ? 70000 : 1500) @(posedge clk);
		clear_seen = 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_key(input int id, input int len, input logic [1:0] md);
		logic [7:0] kb;
		for (int j = 0; j < len; j++) begin
			if ($urandom_range(29) == 0)
				offer(8'($urandom), 1'($urandom), MODE_NONE);
			kb = 8'((id * 157 + j * 61) ^ (id >> 5) ^ (j * j));
			offer(kb, j == len - 1, (j == len - 1) ? md : 2'($urandom_range(1)));
		end
	endtask

	initial begin
		int id, len, target;
		logic [1:0] md;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		offer(8'h00, 1, MODE_QUERY);
		offer(8'hff, 1, MODE_ADD);
		offer(8'hff, 1, MODE_QUERY);
		offer(8'h01, 0, MODE_QUERY);
		offer(8'h80, 0, MODE_ADD);
		offer(8'h5a, 1, MODE_NONE);
		offer(8'h7f, 0, MODE_QUERY);
		offer(8'hfe, 1, MODE_ADD);
		send_key(3, 4, MODE_QUERY);
		send_key(9, 7, MODE_ADD);
		send_key(9, 7, MODE_QUERY);
		offer(8'haa, 0, MODE_ADD);
		offer(8'h00, 1, MODE_CLEAR);
		offer(8'hff, 1, MODE_QUERY);
		send_key(9, 7, MODE_QUERY);
		offer(8'h11, 1, MODE_NONE);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(REG_FILTER_SIZE, 32'd1);
					write_reg(REG_HASH_COUNT, 32'd32);
					write_reg(REG_SEED_ONE, 32'hffffffff);
					write_reg(REG_SEED_TWO, 32'd0);
				end
				1: begin
					write_reg(REG_FILTER_SIZE, 32'd0);
					write_reg(REG_HASH_COUNT, 32'd0);
				end
				2: begin
					write_reg(REG_FILTER_SIZE, 32'h1ffff);
					write_reg(REG_HASH_COUNT, 32'd63);
					write_reg(REG_SEED_ONE, $urandom);
					write_reg(REG_SEED_TWO, $urandom);
				end
				3: begin
					write_reg(REG_FILTER_SIZE, 32'd65536);
					write_reg(REG_HASH_COUNT, 32'd1);
				end
				4: begin
					write_reg(REG_FILTER_SIZE, 32'd97);
					write_reg(REG_HASH_COUNT, $urandom_range(8, 2));
					write_reg(REG_SEED_ONE, $urandom);
				end
				default: begin
					write_reg(REG_FILTER_SIZE, $urandom_range(65536, 2));
					write_reg(REG_HASH_COUNT, $urandom_range(12, 1));
					write_reg(REG_SEED_TWO, $urandom);
				end
			endcase
			tx_idle = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 86 : 28) : 0;
			rx_stall = (ph % 4 == 2) ? 86 : (ph % 4 == 3) ? 28 : 0;
			target = sent + 85;
			while (sent < target) begin
				if (ph == 0 && !hold_done && sent + 40 >= target) begin
					hold_req = 1;
					hold_done = 1;
				end
				if (sent + 20 >= target) begin
					tx_idle = 0;
					rx_stall = 0;
				end
				if ($urandom_range(59) == 0) begin
					offer(8'($urandom), 1'($urandom), MODE_CLEAR);
				end else begin
					id = $urandom_range(40);
					if ($urandom_range(9) == 0)
						id = $urandom;
					len = ($urandom_range(19) == 0) ? $urandom_range(24, 10) : 1 + id % 9;
					md = 2'($urandom_range(1));
					send_key(id, len, md);
				end
			end
		end
		settle();
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bfe_pkg.sv
hw/rtl/bfe_hash.sv
hw/rtl/bfe_mem.sv
hw/rtl/bloom_filter_engine_core.sv
hw/rtl/bfe_chk.sv
tb/sv/tb_bloom_filter_engine_checker.sv
tb/sv/tb_bloom_filter_engine_core.sv
